### sv/weo_pkg.sv
// Shared types, constants and helpers for the wheel encoder odometry block.
`timescale 1ns / 1ps
`default_nettype none
package weo_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TOTAL_WIDTH = 32;
  localparam int REG_WIDTH   = 16;
  localparam int IDX_WIDTH   = 2;
  localparam int DIVD_WIDTH  = 32;
  localparam int DIVR_WIDTH  = 16;
  localparam int STEP_WIDTH  = $clog2(DIVD_WIDTH);

  localparam logic [REG_WIDTH-1:0] MS_PER_SEC    = 16'd1000;
  localparam logic [REG_WIDTH-1:0] PERIOD_RESET  = 16'd10;
  localparam logic [REG_WIDTH-1:0] CPR_RESET     = 16'd1024;
  localparam logic [REG_WIDTH-1:0] CIRC_RESET    = 16'd200;

  localparam logic signed [31:0] SAT_MAX = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN = -32'sd32768;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_PERIOD   = 2'd0,
    REG_CPR      = 2'd1,
    REG_CIRC     = 2'd2,
    REG_VERIFIED = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_LCPS   = 3'd0,
    OP_RCPS   = 3'd1,
    OP_LSPEED = 3'd2,
    OP_RSPEED = 3'd3,
    OP_LDIST  = 3'd4,
    OP_RDIST  = 3'd5
  } op_t;

  // start/done pair between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > SAT_MAX) r = 16'h7fff;
    else if (v < SAT_MIN) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/wheel_encoder_odometry.sv
// Top level of the two-wheel encoder odometry block.
//
// Input stream (s_*): one sample item per accepted beat, carrying the raw pulse
// count and direction pin of each wheel. The block takes one item at a time:
// s_tready is high only while the sequencer is idle.
// Output stream (m_*): one result item per sample - running totals, signed
// deltas, counts per second, speed in mm/s, distance in mm, plus two flags.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no sample is in flight.
// Work per item: six multiply-then-divide operations (rate, speed and
// distance for each wheel) run in turn through one 32x16 multiplier and one
// bit-serial 32/16 divider. Each operation runs through multiply, divider
// start, 32 divide steps and write-back; a result is shown once all six are
// done, and the next sample is taken only after the sequencer returns to
// idle, so one item is worked on at a time; the divider sets the pace.
// The result sits in an output register; a new sample is taken while it waits.
// If the receiver stalls, the next finished result is held in the working
// registers until the output register frees, and no sample is taken meanwhile.
// Reset (rst, synchronous): totals cleared, registers return to their reset
// values (period 10 ms, 1024 counts/rev, 200 mm, unverified), outputs empty.
`timescale 1ns / 1ps
`default_nettype none
module wheel_encoder_odometry (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // left_raw[15:0], left_forward[16], right_raw[32:17], right_forward[33], zero pad
  input  wire logic [39:0]                      s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // left_total, right_total, left_step_count, right_step_count, left_counts_per_sec,
  // right_counts_per_sec, left_speed_mm, right_speed_mm, left_travel_mm,
  // right_travel_mm (lowest bits first)
  output logic [223:0]                          m_tdata,
  // scale_valid[0], sample_valid[1]
  output logic [1:0]                            m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [weo_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [weo_pkg::REG_WIDTH-1:0]    cfg_data
);
  import weo_pkg::*;

  // configuration registers
  logic [REG_WIDTH-1:0] period;
  logic [REG_WIDTH-1:0] cpr;
  logic [REG_WIDTH-1:0] circ;
  logic                 verified;

  always_ff @(posedge clk) begin
    if (rst) begin
      period   <= PERIOD_RESET;
      cpr      <= CPR_RESET;
      circ     <= CIRC_RESET;
      verified <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD:   period   <= cfg_data;
        REG_CPR:      cpr      <= cfg_data;
        REG_CIRC:     circ     <= cfg_data;
        REG_VERIFIED: verified <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic scale;
  assign scale = (cpr != '0) && (circ != '0);

  // input unpacking and signed deltas (negation wraps within the count width)
  logic [COUNT_WIDTH-1:0] in_lraw, in_rraw, in_ldelta, in_rdelta;
  logic                   in_lfwd, in_rfwd;

  always_comb begin
    in_lraw   = s_tdata[15:0];
    in_lfwd   = s_tdata[16];
    in_rraw   = s_tdata[32:17];
    in_rfwd   = s_tdata[33];
    in_ldelta = in_lfwd ? in_lraw : COUNT_WIDTH'(0) - in_lraw;
    in_rdelta = in_rfwd ? in_rraw : COUNT_WIDTH'(0) - in_rraw;
  end

  state_t state;
  op_t    op;
  logic   s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // working registers
  logic [TOTAL_WIDTH-1:0] ltot, rtot;
  logic [COUNT_WIDTH-1:0] ldel, rdel;
  logic [15:0]            lcps, rcps, lspd, rspd;
  logic [TOTAL_WIDTH-1:0] ldist, rdist;
  logic [DIVD_WIDTH-1:0]  prod;
  logic [DIVD_WIDTH-1:0]  mag;
  logic                   neg;

  // shared multiplier operands
  logic [DIVD_WIDTH-1:0]  mul_a;
  logic [DIVR_WIDTH-1:0]  mul_b;
  logic [DIVD_WIDTH+DIVR_WIDTH-1:0] mul_full;
  logic [DIVR_WIDTH-1:0]  div_dvs;

  always_comb begin
    case (op)
      OP_LCPS:   begin mul_a = 32'($signed(ldel)); mul_b = MS_PER_SEC; end
      OP_RCPS:   begin mul_a = 32'($signed(rdel)); mul_b = MS_PER_SEC; end
      OP_LSPEED: begin mul_a = 32'($signed(lcps)); mul_b = circ; end
      OP_RSPEED: begin mul_a = 32'($signed(rcps)); mul_b = circ; end
      OP_LDIST:  begin mul_a = ltot; mul_b = circ; end
      OP_RDIST:  begin mul_a = rtot; mul_b = circ; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
    mul_full = mul_a * mul_b;
    div_dvs  = ((op == OP_LCPS) || (op == OP_RCPS)) ? period : cpr;
  end

  // divider, fed with the magnitude of the held product
  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [DIVD_WIDTH-1:0] div_q;

  assign div_ctl.start = (state == ST_DIV);
  assign mag = prod[DIVD_WIDTH-1] ? DIVD_WIDTH'(0) - prod : prod;

  weo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (mag),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // signed quotient, truncated toward zero
  logic signed [31:0] res;
  assign res = neg ? $signed(32'(0) - div_q) : $signed(div_q);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_LCPS;
      ltot  <= '0;
      rtot  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            ltot  <= ltot + 32'($signed(in_ldelta));
            rtot  <= rtot + 32'($signed(in_rdelta));
            op    <= OP_LCPS;
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_DIV;
        ST_DIV:  state <= ST_WAIT;
        ST_WAIT: begin
          if (div_sts.done) begin
            if (op == OP_RDIST) begin
              state <= ST_DONE;
            end else begin
              op    <= op_t'(op + 3'd1);
              state <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      ldel <= in_ldelta;
      rdel <= in_rdelta;
    end
    if (state == ST_MUL) prod <= mul_full[DIVD_WIDTH-1:0];
    if (state == ST_DIV) neg <= prod[DIVD_WIDTH-1];
    if ((state == ST_WAIT) && div_sts.done) begin
      case (op)
        OP_LCPS:   lcps  <= (period == '0) ? 16'h0 : sat16(res);
        OP_RCPS:   rcps  <= (period == '0) ? 16'h0 : sat16(res);
        OP_LSPEED: lspd  <= scale ? sat16(res) : 16'h0;
        OP_RSPEED: rspd  <= scale ? sat16(res) : 16'h0;
        OP_LDIST:  ldist <= scale ? res : 32'h0;
        OP_RDIST:  rdist <= scale ? res : 32'h0;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {rdist, ldist, rspd, lspd, rcps, lcps, rdel, ldel, rtot, ltot};
      m_tuser <= {verified, scale};
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("sample taken while a sample is in flight");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == ST_WAIT))
    else $error("divider finished outside the wait step");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_noscale_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[223:128] == '0))
    else $error("millimetre outputs nonzero without valid scale");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire

### sv/weo_div.sv
// Radix-2 restoring divider, unsigned 32 by 16 bits, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module weo_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire weo_pkg::div_ctl_t               ctl,
  input  wire logic [weo_pkg::DIVD_WIDTH-1:0]  dividend,
  input  wire logic [weo_pkg::DIVR_WIDTH-1:0]  divisor,
  output weo_pkg::div_sts_t                    sts,
  output logic [weo_pkg::DIVD_WIDTH-1:0]       quotient
);
  import weo_pkg::*;

  logic                  busy;
  logic                  done;
  logic [STEP_WIDTH-1:0] step;
  logic [DIVR_WIDTH-1:0] rem;
  logic [DIVR_WIDTH-1:0] dvs;
  logic [DIVD_WIDTH-1:0] quo;

  logic [DIVR_WIDTH:0]   shifted;
  logic                  fits;
  logic [DIVR_WIDTH:0]   diff;

  always_comb begin
    shifted = {rem, quo[DIVD_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_WIDTH'(DIVD_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIVR_WIDTH-1:0] : shifted[DIVR_WIDTH-1:0];
      quo <= {quo[DIVD_WIDTH-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule
`default_nettype wire

### verif/odometry_checker.sv
// Checker for the wheel encoder odometry block: predicts every result item and compares it.
`timescale 1ns / 1ps
module odometry_checker
  import weo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [39:0]          s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [223:0]         m_tdata,
  input  logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   results_checked
);

  typedef struct {
    logic signed [31:0] l_total;
    logic signed [31:0] r_total;
    logic signed [15:0] l_delta;
    logic signed [15:0] r_delta;
    logic signed [15:0] l_cps;
    logic signed [15:0] r_cps;
    logic signed [15:0] l_speed;
    logic signed [15:0] r_speed;
    logic signed [31:0] l_dist;
    logic signed [31:0] r_dist;
    logic               scale_ok;
    logic               verified;
  } odo_result_t;

  // shadow registers and wheel totals
  logic [15:0] period_ms;
  logic [15:0] cpr;
  logic [15:0] circ;
  logic        verified;
  logic [31:0] l_accum;
  logic [31:0] r_accum;

  odo_result_t odometry_q[$];

  initial begin
    errors = 0;
    pending = 0;
    results_checked = 0;
  end

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // direction low negates, wrapping within 16 bits
  function automatic logic signed [15:0] signed_delta(input logic [15:0] raw, input logic fwd);
    return fwd ? raw : 16'(16'd0 - raw);
  endfunction

  function automatic logic signed [15:0] rate_per_sec(input logic signed [15:0] delta);
    longint d;
    longint p;
    d = delta;
    p = period_ms;
    if (p == 0) return 16'h0000;
    return clamp16((d * 1000) / p);
  endfunction

  function automatic logic signed [15:0] speed_mm(input logic signed [15:0] cps);
    longint c;
    longint w;
    longint n;
    c = cps;
    w = circ;
    n = cpr;
    return clamp16((c * w) / n);
  endfunction

  // full product, wrapped to 32 bits, then truncating division
  function automatic logic signed [31:0] distance_mm(input logic signed [31:0] total);
    longint t;
    longint w;
    longint n;
    logic signed [31:0] wrapped;
    t = total;
    w = circ;
    n = cpr;
    wrapped = 32'(t * w);
    return 32'(longint'(wrapped) / n);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t result %0d: %s", $time, results_checked, what);
    errors++;
  endtask

  task automatic check_field(input string name, input longint got_v, input longint want_v);
    if (got_v != want_v)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
  endtask

  always @(posedge clk) begin : watch
    odo_result_t want;
    odo_result_t got;
    logic signed [15:0] ld;
    logic signed [15:0] rd;
    if (rst) begin
      period_ms = PERIOD_RESET;
      cpr = CPR_RESET;
      circ = CIRC_RESET;
      verified = 1'b0;
      l_accum = '0;
      r_accum = '0;
      odometry_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PERIOD:   period_ms = cfg_data;
          REG_CPR:      cpr = cfg_data;
          REG_CIRC:     circ = cfg_data;
          REG_VERIFIED: verified = cfg_data[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.l_total  = m_tdata[31:0];
        got.r_total  = m_tdata[63:32];
        got.l_delta  = m_tdata[79:64];
        got.r_delta  = m_tdata[95:80];
        got.l_cps    = m_tdata[111:96];
        got.r_cps    = m_tdata[127:112];
        got.l_speed  = m_tdata[143:128];
        got.r_speed  = m_tdata[159:144];
        got.l_dist   = m_tdata[191:160];
        got.r_dist   = m_tdata[223:192];
        got.scale_ok = m_tuser[0];
        got.verified = m_tuser[1];
        if (odometry_q.size() == 0) begin
          report_mismatch("result item with no sample outstanding");
        end else begin
          want = odometry_q.pop_front();
          check_field("left_total", got.l_total, want.l_total);
          check_field("right_total", got.r_total, want.r_total);
          check_field("left_step_count", got.l_delta, want.l_delta);
          check_field("right_step_count", got.r_delta, want.r_delta);
          check_field("left_counts_per_sec", got.l_cps, want.l_cps);
          check_field("right_counts_per_sec", got.r_cps, want.r_cps);
          check_field("left_speed_mm", got.l_speed, want.l_speed);
          check_field("right_speed_mm", got.r_speed, want.r_speed);
          check_field("left_travel_mm", got.l_dist, want.l_dist);
          check_field("right_travel_mm", got.r_dist, want.r_dist);
          check_field("scale_valid", got.scale_ok, want.scale_ok);
          check_field("sample_valid", got.verified, want.verified);
        end
        results_checked++;
      end

      if (s_tvalid && s_tready) begin
        ld = signed_delta(s_tdata[15:0], s_tdata[16]);
        rd = signed_delta(s_tdata[32:17], s_tdata[33]);
        l_accum = l_accum + {{16{ld[15]}}, ld};
        r_accum = r_accum + {{16{rd[15]}}, rd};
        want.l_total  = l_accum;
        want.r_total  = r_accum;
        want.l_delta  = ld;
        want.r_delta  = rd;
        want.l_cps    = rate_per_sec(ld);
        want.r_cps    = rate_per_sec(rd);
        want.scale_ok = (cpr != 0) && (circ != 0);
        want.verified = verified;
        // millimetre outputs only with both scale registers set
        if (want.scale_ok) begin
          want.l_speed = speed_mm(want.l_cps);
          want.r_speed = speed_mm(want.r_cps);
          want.l_dist  = distance_mm(l_accum);
          want.r_dist  = distance_mm(r_accum);
        end else begin
          want.l_speed = '0;
          want.r_speed = '0;
          want.l_dist  = '0;
          want.r_dist  = '0;
        end
        odometry_q.push_back(want);
      end
    end
    pending <= odometry_q.size();
  end

endmodule

### verif/testbench.sv
// Testbench top for the wheel encoder odometry block: sample stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import weo_pkg::*;

  localparam int HALF_PERIOD       = 6;
  localparam int RESET_CYCLES      = 8;
  localparam int HOLD_CYCLES       = 1500;  // long enough for two items to back up
  localparam int DRAIN_LIMIT       = 20000;
  localparam int ITEMS_PER_SETTING = 78;
  localparam int SETTINGS_PER_MODE = 3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // left_raw[15:0], left_forward[16], right_raw[32:17], right_forward[33], zero pad
  logic [39:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // left_total, right_total, left_delta, right_delta, left/right counts per sec,
  // left/right speed, left/right distance (lowest bits first)
  logic [223:0]         m_tdata;
  // scale_valid[0], sample_valid[1]
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index = '0;
  logic [REG_WIDTH-1:0] cfg_data = '0;

  int errors;
  int pending;
  int results_checked;

  // idle chances in percent, changed per phase by the stimulus
  int tx_idle_pct = 15;
  int rx_idle_pct = 84;

  // long receiver stall: stimulus toggles the request, receiver counts it out
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  int samples_sent = 0;
  int settings_used = 0;

  always #HALF_PERIOD clk = ~clk;

  wheel_encoder_odometry i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  odometry_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending),
    .results_checked(results_checked)
  );

  // Receiver: random back-pressure, or a long hold when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one sample item, idling first at random, and wait for it to be taken.
  // s_tvalid stays high afterwards; drain_results lowers it.
  task automatic send_sample(input logic [15:0] l_raw, input logic l_fwd,
                             input logic [15:0] r_raw, input logic r_fwd);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, r_fwd, r_raw, l_fwd, l_raw};
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle.
  task automatic drain_results(input int settle);
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [REG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_settings(input logic [15:0] period, input logic [15:0] counts,
                                input logic [15:0] circumference, input logic [15:0] verify);
    write_reg(REG_PERIOD, period);
    write_reg(REG_CPR, counts);
    write_reg(REG_CIRC, circumference);
    write_reg(REG_VERIFIED, verify);
    settings_used++;
  endtask

  // Register values biased towards zero, one and full scale.
  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hffff;
      3: return 16'($urandom_range(2, 20));
      4: return 16'($urandom_range(100, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Raw counts: signed extremes, small moves either way, or anything at all.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4: return 16'h0001;
      5, 6: return 16'($urandom_range(0, 200));
      7: return 16'(0 - $urandom_range(1, 200));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: 10 ms, 1024 counts/rev, 200 mm, unverified.
    send_sample(16'h0000, 1'b1, 16'h0000, 1'b1);
    send_sample(16'h0000, 1'b0, 16'h0000, 1'b0);
    send_sample(16'h7fff, 1'b1, 16'h8000, 1'b1);
    // most negative count negated wraps onto itself
    send_sample(16'h8000, 1'b0, 16'h7fff, 1'b0);
    send_sample(16'hffff, 1'b0, 16'h0001, 1'b0);
    send_sample(16'h5555, 1'b1, 16'haaaa, 1'b0);

    // 1 ms period saturates the rate; huge circumference wraps the distance.
    // Upper data bits on the flag register must be dropped.
    drain_results(8);
    write_settings(16'd1, 16'd1, 16'hffff, 16'hffff);
    send_sample(16'h7fff, 1'b1, 16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b1, 16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b1, 16'h7fff, 1'b0);
    send_sample(16'haaaa, 1'b1, 16'h5555, 1'b1);

    // zero period and zero counts per revolution
    drain_results(8);
    write_settings(16'd0, 16'd0, 16'd1234, 16'hfffe);
    send_sample(16'h1234, 1'b1, 16'hfedc, 1'b0);
    send_sample(16'h8000, 1'b1, 16'h8000, 1'b0);

    // longest period, zero circumference
    drain_results(8);
    write_settings(16'hffff, 16'hffff, 16'd0, 16'd1);
    send_sample(16'hffff, 1'b1, 16'hffff, 1'b1);
    send_sample(16'h0001, 1'b0, 16'h7fff, 1'b1);

    // odd ratios so negative quotients truncate towards zero
    drain_results(8);
    write_settings(16'd3, 16'd7, 16'hffff, 16'd1);
    repeat (4) send_sample(pick_raw(), 1'($urandom_range(1)), pick_raw(), 1'($urandom_range(1)));

    // Random part: three stall patterns, each over several register settings.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 15; rx_idle_pct = 84; end
        1: begin tx_idle_pct = 84; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
        drain_results(8);
        write_settings(pick_reg_value(), pick_reg_value(), pick_reg_value(), 16'($urandom));
        // receiver holds off while the sender keeps offering; input backs up
        if (mode == 2 && s == 0) hold_req = ~hold_req;
        repeat (ITEMS_PER_SETTING)
          send_sample(pick_raw(), 1'($urandom_range(1)), pick_raw(), 1'($urandom_range(1)));
      end
    end

    drain_results(250);
    if (pending != 0) $display("ERROR: %0d results never arrived", pending);

    $display("Covered %0d samples over %0d register settings; %0d results compared.",
             samples_sent, settings_used, results_checked);
    $display("Included zero period, zero scale, saturation and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/weo_pkg.sv
sv/weo_div.sv
sv/wheel_encoder_odometry.sv
verif/odometry_checker.sv
verif/testbench.sv
